/* rtl/core/stack_machine_executor_assert.svh */
// Assertion macros of the stack machine executor, used by sme_controller.
// Needs i_clk and i_rst_n in the scope of the module that uses them.
`ifndef STACK_MACHINE_EXECUTOR_ASSERT_SVH
`define STACK_MACHINE_EXECUTOR_ASSERT_SVH
// same-cycle implication
`define SME_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define SME_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

/* rtl/core/sme_pkg.sv */
// Shared types and codes of the stack machine executor.
// No dependencies.
`timescale 1ns / 1ps
package sme_pkg;

    localparam int DATA_W = 64;

    typedef enum logic [3:0] {
        OP_NOP     = 4'd0,
        OP_PUSH    = 4'd1,
        OP_DUP_REL = 4'd2,
        OP_PLUS    = 4'd3,
        OP_MINUS   = 4'd4,
        OP_MULT    = 4'd5,
        OP_DIV     = 4'd6,
        OP_JMP     = 4'd7,
        OP_JMP_NZ  = 4'd8,
        OP_EQ      = 4'd9,
        OP_HALT    = 4'd10,
        OP_PRINT   = 4'd11
    } t_opcode;

    typedef enum logic [2:0] {
        ERR_OK           = 3'd0,
        ERR_OVERFLOW     = 3'd1,
        ERR_UNDERFLOW    = 3'd2,
        ERR_ILLEGAL_INST = 3'd3,
        ERR_BAD_FETCH    = 3'd4,
        ERR_ILLEGAL_OPND = 3'd5,
        ERR_DIV_ZERO     = 3'd6,
        ERR_PROG_FULL    = 3'd7
    } t_err;

    typedef struct packed {
        logic load;
        logic fetch;
        logic rd_issue;
        logic set_err;
        logic alu_start;
        logic commit;
    } t_cmd;

    typedef struct packed {
        t_err err;
        logic is_long;
        logic alu_done;
    } t_status;

endpackage

/* rtl/core/sme_alu.sv */
// Multi-cycle multiply (32x32 partial products) and restoring signed divide.
// Depends on sme_pkg.
`timescale 1ns / 1ps
module sme_alu (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic                       i_is_div,
    input  logic [sme_pkg::DATA_W-1:0] i_a,
    input  logic [sme_pkg::DATA_W-1:0] i_b,
    output logic                       o_done,
    output logic [sme_pkg::DATA_W-1:0] o_result
);
    logic        r_busy;
    logic        r_is_div;
    logic [5:0]  r_step;
    logic        r_done;
    logic [63:0] r_res;
    logic [63:0] r_a;
    logic [63:0] r_b;
    logic [63:0] r_prod;
    logic [63:0] r_acc;
    logic [63:0] r_rem;
    logic [63:0] r_quo;
    logic [63:0] r_dvs;
    logic        r_neg;

    logic [31:0] mx;
    logic [31:0] my;
    logic [64:0] rem_sh;
    logic [64:0] diff;
    logic        ge;
    logic [63:0] q_fin;

    always_comb begin
        case (r_step[1:0])
            2'd0: begin
                mx = r_a[31:0];
                my = r_b[31:0];
            end
            2'd1: begin
                mx = r_a[31:0];
                my = r_b[63:32];
            end
            default: begin
                mx = r_a[63:32];
                my = r_b[31:0];
            end
        endcase
        rem_sh = {r_rem, r_quo[63]};
        diff   = rem_sh - {1'b0, r_dvs};
        ge     = rem_sh >= {1'b0, r_dvs};
        q_fin  = {r_quo[62:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy   <= 1'b1;
                r_is_div <= i_is_div;
                r_step   <= '0;
                r_a      <= i_a;
                r_b      <= i_b;
                r_acc    <= '0;
                r_rem    <= '0;
                r_quo    <= i_a[63] ? (64'd0 - i_a) : i_a;
                r_dvs    <= i_b[63] ? (64'd0 - i_b) : i_b;
                r_neg    <= i_a[63] ^ i_b[63];
            end else if (r_busy) begin
                r_step <= r_step + 6'd1;
                if (r_is_div) begin
                    r_rem <= ge ? diff[63:0] : rem_sh[63:0];
                    r_quo <= q_fin;
                    if (r_step == 6'd63) begin
                        r_res  <= r_neg ? (64'd0 - q_fin) : q_fin;
                        r_done <= 1'b1;
                        r_busy <= 1'b0;
                    end
                end else begin
                    r_prod <= mx * my;
                    if (r_step == 6'd1) begin
                        r_acc <= r_prod;
                    end else if (r_step == 6'd2) begin
                        r_acc <= r_acc + {r_prod[31:0], 32'd0};
                    end else if (r_step == 6'd3) begin
                        r_res  <= r_acc + {r_prod[31:0], 32'd0};
                        r_done <= 1'b1;
                        r_busy <= 1'b0;
                    end
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;
endmodule

/* rtl/core/sme_controller.sv */
// Sequencer of the stack machine executor: handshakes and datapath commands.
// Depends on sme_pkg and stack_machine_executor_assert.svh.
`timescale 1ns / 1ps
`include "stack_machine_executor_assert.svh"
module sme_controller (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_mode,
    output logic             o_ready,
    output logic             o_valid,
    input  logic             i_ready,
    output sme_pkg::t_cmd    o_cmd,
    input  sme_pkg::t_status i_status
);
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_EXEC,
        S_ALU,
        S_RESP
    } t_state;

    t_state r_state;
    t_state n_state;
    sme_pkg::t_cmd cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_mode) begin
                        cmd.fetch = 1'b1;
                        n_state   = S_DECODE;
                    end else begin
                        cmd.load = 1'b1;
                        n_state  = S_RESP;
                    end
                end
            end
            S_DECODE: begin
                cmd.rd_issue = 1'b1;
                if (i_status.err != sme_pkg::ERR_OK) begin
                    cmd.set_err = 1'b1;
                    n_state     = S_RESP;
                end else begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_status.is_long) begin
                    cmd.alu_start = 1'b1;
                    n_state       = S_ALU;
                end else begin
                    cmd.commit = 1'b1;
                    n_state    = S_RESP;
                end
            end
            S_ALU: begin
                if (i_status.alu_done) begin
                    cmd.commit = 1'b1;
                    n_state    = S_RESP;
                end
            end
            S_RESP: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd   = cmd;
    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_RESP);

    `SME_ASSERT_NOW(a_cmd_excl, cmd.commit, !cmd.set_err && !cmd.load, "commit with error or load")
    `SME_ASSERT_NOW(a_alu_long, cmd.alu_start, i_status.is_long, "alu start on short op")
    `SME_ASSERT_NOW(a_done_wait, i_status.alu_done, r_state == S_ALU, "alu done while not waiting")
    `SME_ASSERT_NEXT(a_busy_after, i_valid && o_ready, !o_ready, "ready right after accept")
endmodule

/* rtl/core/sme_datapath.sv */
// Machine state, program and stack memories, checks and instruction effects.
// Depends on sme_pkg and sme_alu.
`timescale 1ns / 1ps
module sme_datapath #(
    parameter int STACK_DEPTH   = 1024,
    parameter int PROGRAM_DEPTH = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  sme_pkg::t_cmd              i_cmd,
    output sme_pkg::t_status           o_status,
    input  logic [3:0]                 i_opcode,
    input  logic [sme_pkg::DATA_W-1:0] i_operand,
    output logic [2:0]                 o_error_code,
    output logic [sme_pkg::DATA_W-1:0] o_next_pointer,
    output logic [10:0]                o_stack_count,
    output logic [sme_pkg::DATA_W-1:0] o_top_value,
    output logic                       o_halted,
    output logic                       o_print_valid,
    output logic [sme_pkg::DATA_W-1:0] o_print_value,
    output logic [10:0]                o_program_count
);
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int CW  = $clog2(STACK_DEPTH + 1);
    localparam int PAW = $clog2(PROGRAM_DEPTH);
    localparam int LW  = $clog2(PROGRAM_DEPTH + 1);

    logic [63:0]       r_ip;
    logic [CW-1:0]     r_cnt;
    logic [LW-1:0]     r_len;
    logic              r_halt;
    logic [63:0]       r_top;
    sme_pkg::t_err     r_err;
    logic              r_pv;
    logic [63:0]       r_pval;
    sme_pkg::t_opcode  r_op;
    logic [63:0]       r_opnd;
    logic [63:0]       r_sd;
    logic [63:0]       r_stack_mem [STACK_DEPTH];
    logic [3:0]        r_op_mem    [PROGRAM_DEPTH];
    logic [63:0]       r_opnd_mem  [PROGRAM_DEPTH];

    sme_pkg::t_err     err;
    logic              is_long;
    logic              full;
    logic [63:0]       n64;
    logic [63:0]       dup_idx;
    logic [CW-1:0]     cm2;
    logic [SAW-1:0]    rd_addr;
    logic [63:0]       ip_inc;
    logic [63:0]       top_pop;
    logic [63:0]       res;
    logic              alu_done;
    logic [63:0]       alu_res;

    logic [63:0]       n_ip;
    logic [CW-1:0]     n_cnt;
    logic [63:0]       n_top;
    logic              n_halt;
    logic              n_pv;
    logic              wr_en;
    logic [SAW-1:0]    wr_addr;
    logic [63:0]       wr_data;

    sme_alu u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.alu_start),
        .i_is_div (r_op == sme_pkg::OP_DIV),
        .i_a      (r_sd),
        .i_b      (r_top),
        .o_done   (alu_done),
        .o_result (alu_res)
    );

    always_comb begin
        n64     = 64'(r_cnt);
        full    = (r_cnt == CW'(STACK_DEPTH));
        dup_idx = n64 - 64'd1 - r_opnd;
        cm2     = r_cnt - CW'(2);
        rd_addr = (r_op == sme_pkg::OP_DUP_REL) ? dup_idx[SAW-1:0] : cm2[SAW-1:0];
        is_long = (r_op == sme_pkg::OP_MULT) || (r_op == sme_pkg::OP_DIV);
        err     = sme_pkg::ERR_OK;
        if (r_ip[63] || (r_ip >= 64'(r_len))) begin
            err = sme_pkg::ERR_BAD_FETCH;
        end else begin
            case (r_op)
                sme_pkg::OP_PUSH: begin
                    if (full) err = sme_pkg::ERR_OVERFLOW;
                end
                sme_pkg::OP_DUP_REL: begin
                    if (full) err = sme_pkg::ERR_OVERFLOW;
                    else if (!r_opnd[63] && (r_opnd >= n64)) err = sme_pkg::ERR_UNDERFLOW;
                    else if (r_opnd[63]) err = sme_pkg::ERR_ILLEGAL_OPND;
                end
                sme_pkg::OP_PLUS, sme_pkg::OP_MINUS, sme_pkg::OP_MULT, sme_pkg::OP_EQ: begin
                    if (r_cnt < CW'(2)) err = sme_pkg::ERR_UNDERFLOW;
                end
                sme_pkg::OP_DIV: begin
                    if (r_cnt < CW'(2)) err = sme_pkg::ERR_UNDERFLOW;
                    else if (r_top == 64'd0) err = sme_pkg::ERR_DIV_ZERO;
                end
                sme_pkg::OP_JMP_NZ, sme_pkg::OP_PRINT: begin
                    if (r_cnt == '0) err = sme_pkg::ERR_UNDERFLOW;
                end
                sme_pkg::OP_NOP, sme_pkg::OP_JMP, sme_pkg::OP_HALT: begin
                    err = sme_pkg::ERR_OK;
                end
                default: begin
                    err = sme_pkg::ERR_ILLEGAL_INST;
                end
            endcase
        end
    end

    always_comb begin
        ip_inc  = r_ip + 64'd1;
        top_pop = (r_cnt == CW'(1)) ? 64'd0 : r_sd;
        case (r_op)
            sme_pkg::OP_PLUS:  res = r_sd + r_top;
            sme_pkg::OP_MINUS: res = r_sd - r_top;
            sme_pkg::OP_EQ:    res = {63'd0, r_sd == r_top};
            default:           res = alu_res;
        endcase
        n_ip    = ip_inc;
        n_cnt   = r_cnt;
        n_top   = r_top;
        n_halt  = r_halt;
        n_pv    = 1'b0;
        wr_en   = 1'b0;
        wr_addr = r_cnt[SAW-1:0];
        wr_data = r_opnd;
        case (r_op)
            sme_pkg::OP_PUSH: begin
                wr_en = 1'b1;
                n_cnt = r_cnt + CW'(1);
                n_top = r_opnd;
            end
            sme_pkg::OP_DUP_REL: begin
                wr_en   = 1'b1;
                wr_data = r_sd;
                n_cnt   = r_cnt + CW'(1);
                n_top   = r_sd;
            end
            sme_pkg::OP_PLUS, sme_pkg::OP_MINUS, sme_pkg::OP_MULT,
            sme_pkg::OP_DIV, sme_pkg::OP_EQ: begin
                wr_en   = 1'b1;
                wr_addr = cm2[SAW-1:0];
                wr_data = res;
                n_cnt   = r_cnt - CW'(1);
                n_top   = res;
            end
            sme_pkg::OP_JMP: begin
                n_ip = r_opnd;
            end
            sme_pkg::OP_JMP_NZ: begin
                if (r_top != 64'd0) begin
                    n_ip  = r_opnd;
                    n_cnt = r_cnt - CW'(1);
                    n_top = top_pop;
                end
            end
            sme_pkg::OP_HALT: begin
                n_ip   = r_ip;
                n_halt = 1'b1;
            end
            sme_pkg::OP_PRINT: begin
                n_pv  = 1'b1;
                n_cnt = r_cnt - CW'(1);
                n_top = top_pop;
            end
            default: begin
                n_ip = ip_inc;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fetch) begin
            r_op   <= sme_pkg::t_opcode'(r_op_mem[r_ip[PAW-1:0]]);
            r_opnd <= r_opnd_mem[r_ip[PAW-1:0]];
        end
        if (i_cmd.load && (r_len != LW'(PROGRAM_DEPTH))) begin
            r_op_mem[r_len[PAW-1:0]]   <= i_opcode;
            r_opnd_mem[r_len[PAW-1:0]] <= i_operand;
        end
        if (i_cmd.rd_issue) begin
            r_sd <= r_stack_mem[rd_addr];
        end
        if (i_cmd.commit && wr_en) begin
            r_stack_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ip   <= '0;
            r_cnt  <= '0;
            r_len  <= '0;
            r_halt <= 1'b0;
            r_top  <= '0;
            r_err  <= sme_pkg::ERR_OK;
            r_pv   <= 1'b0;
            r_pval <= '0;
        end else begin
            if (i_cmd.load) begin
                r_pv   <= 1'b0;
                r_pval <= '0;
                if (r_len == LW'(PROGRAM_DEPTH)) begin
                    r_err <= sme_pkg::ERR_PROG_FULL;
                end else begin
                    r_err <= sme_pkg::ERR_OK;
                    r_len <= r_len + LW'(1);
                end
            end
            if (i_cmd.set_err) begin
                r_err  <= err;
                r_pv   <= 1'b0;
                r_pval <= '0;
            end
            if (i_cmd.commit) begin
                r_err  <= sme_pkg::ERR_OK;
                r_ip   <= n_ip;
                r_cnt  <= n_cnt;
                r_top  <= n_top;
                r_halt <= n_halt;
                r_pv   <= n_pv;
                r_pval <= n_pv ? r_top : 64'd0;
            end
        end
    end

    assign o_status.err      = err;
    assign o_status.is_long  = is_long;
    assign o_status.alu_done = alu_done;

    assign o_error_code    = r_err;
    assign o_next_pointer  = r_ip;
    assign o_stack_count   = 11'(r_cnt);
    assign o_top_value     = r_top;
    assign o_halted        = r_halt;
    assign o_print_valid   = r_pv;
    assign o_print_value   = r_pval;
    assign o_program_count = 11'(r_len);
endmodule

/* rtl/core/stack_machine_executor.sv */
// Stack machine executor, top level: controller plus datapath.
// Depends on sme_pkg, sme_controller, sme_datapath.
// One item is taken at a time. A load writes program memory (or flags program
// full) at the accept edge. A step fetches from program memory at the accept
// edge, then decodes and reads the stack, then executes, or skips execute when
// decode finds an error. Multiply adds three 32x32 partial products, divide a
// one-bit-per-cycle restoring loop. The result then holds until taken, and the
// next item is accepted in the cycle after that. No clearing pass.
`timescale 1ns / 1ps
module stack_machine_executor #(
    parameter int STACK_DEPTH   = 1024,
    parameter int PROGRAM_DEPTH = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_mode,
    input  logic [3:0]                 i_opcode,
    input  logic [sme_pkg::DATA_W-1:0] i_operand,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [2:0]                 o_error_code,
    output logic [sme_pkg::DATA_W-1:0] o_next_pointer,
    output logic [10:0]                o_stack_count,
    output logic [sme_pkg::DATA_W-1:0] o_top_value,
    output logic                       o_halted,
    output logic                       o_print_valid,
    output logic [sme_pkg::DATA_W-1:0] o_print_value,
    output logic [10:0]                o_program_count
);
    sme_pkg::t_cmd    cmd;
    sme_pkg::t_status status;

    sme_controller u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_mode   (i_mode),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_cmd    (cmd),
        .i_status (status)
    );

    sme_datapath #(
        .STACK_DEPTH   (STACK_DEPTH),
        .PROGRAM_DEPTH (PROGRAM_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_opcode        (i_opcode),
        .i_operand       (i_operand),
        .o_error_code    (o_error_code),
        .o_next_pointer  (o_next_pointer),
        .o_stack_count   (o_stack_count),
        .o_top_value     (o_top_value),
        .o_halted        (o_halted),
        .o_print_valid   (o_print_valid),
        .o_print_value   (o_print_value),
        .o_program_count (o_program_count)
    );
endmodule

/* verif/tb.sv */
// Self-checking testbench for stack_machine_executor.
// Directed table, then random load/step programs checked against an internal model.
// Depends on sme_pkg and the stack_machine_executor RTL.
`timescale 1ns / 1ps
module tb;

    localparam int SDEPTH = 1024;
    localparam int PDEPTH = 1024;
    localparam int IDLE_LIMIT = 3000;
    localparam logic [63:0] WMIN = 64'h8000_0000_0000_0000;
    localparam logic [63:0] WMAX = 64'h7fff_ffff_ffff_ffff;

    typedef struct {
        sme_pkg::t_err err;
        logic [63:0]   ptr;
        logic [10:0]   scnt;
        logic [63:0]   top;
        logic          halt;
        logic          pv;
        logic [63:0]   pval;
        logic [10:0]   pcnt;
    } t_result;

    typedef struct {
        bit          m;
        logic [3:0]  op;
        logic [63:0] arg;
        bit          typed;
        t_result     res;
    } t_dir_row;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_ready;
    logic        i_mode = 0;
    logic [3:0]  i_opcode = '0;
    logic [63:0] i_operand = '0;
    logic        o_valid;
    logic        i_ready = 0;
    logic [2:0]  o_error_code;
    logic [63:0] o_next_pointer;
    logic [10:0] o_stack_count;
    logic [63:0] o_top_value;
    logic        o_halted;
    logic        o_print_valid;
    logic [63:0] o_print_value;
    logic [10:0] o_program_count;

    stack_machine_executor DUT (.*);

    // machine model state
    logic [63:0] stk [SDEPTH];
    logic [3:0]  prog_op [PDEPTH];
    logic [63:0] prog_arg [PDEPTH];
    int          scnt_m = 0;
    int          plen_m = 0;
    logic [63:0] ptr_m = '0;
    logic        halt_m = 0;

    t_result  expect_q[$];
    t_dir_row dir_q[$];
    int       fail_count = 0;
    int       beats_in = 0;
    int       beats_out = 0;
    int       err_seen[8];
    int       burst_left = 0;
    bit       hold_req = 0;
    bit       hold_done = 0;
    int       idle_cycles = 0;
    int       cyc = 0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 5))
            0: return WMIN;
            1: return WMAX;
            2: return '0;
            3: return '1;
            4: return 64'($urandom_range(0, 20));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic t_result exec_model(bit m, logic [3:0] op, logic [63:0] arg);
        t_result       r;
        sme_pkg::t_err e;
        logic [63:0]   ip, iarg, a, b;
        logic [3:0]    iop;
        int            n;
        r = '{sme_pkg::ERR_OK, '0, '0, '0, 1'b0, 1'b0, '0, '0};
        e = sme_pkg::ERR_OK;
        n = scnt_m;
        if (!m) begin
            if (plen_m >= PDEPTH) begin
                e = sme_pkg::ERR_PROG_FULL;
            end else begin
                prog_op[plen_m] = op;
                prog_arg[plen_m] = arg;
                plen_m++;
            end
        end else begin
            ip = ptr_m;
            if (ip[63] || ip >= 64'(plen_m)) begin
                e = sme_pkg::ERR_BAD_FETCH;
            end else begin
                iop = prog_op[ip[9:0]];
                iarg = prog_arg[ip[9:0]];
                case (iop)
                    sme_pkg::OP_NOP: ptr_m = ip + 1;
                    sme_pkg::OP_PUSH: begin
                        if (n >= SDEPTH) e = sme_pkg::ERR_OVERFLOW;
                        else begin
                            stk[n] = iarg;
                            scnt_m = n + 1;
                            ptr_m = ip + 1;
                        end
                    end
                    sme_pkg::OP_DUP_REL: begin
                        if (n >= SDEPTH) e = sme_pkg::ERR_OVERFLOW;
                        else if (!iarg[63] && iarg >= 64'(n)) e = sme_pkg::ERR_UNDERFLOW;
                        else if (iarg[63]) e = sme_pkg::ERR_ILLEGAL_OPND;
                        else begin
                            stk[n] = stk[n - 1 - int'(iarg)];
                            scnt_m = n + 1;
                            ptr_m = ip + 1;
                        end
                    end
                    sme_pkg::OP_PLUS, sme_pkg::OP_MINUS, sme_pkg::OP_MULT,
                    sme_pkg::OP_DIV, sme_pkg::OP_EQ: begin
                        if (n < 2) e = sme_pkg::ERR_UNDERFLOW;
                        else begin
                            a = stk[n - 2];
                            b = stk[n - 1];
                            case (iop)
                                sme_pkg::OP_PLUS:  a = a + b;
                                sme_pkg::OP_MINUS: a = a - b;
                                sme_pkg::OP_MULT:  a = a * b;
                                sme_pkg::OP_DIV: begin
                                    if (b == '0) e = sme_pkg::ERR_DIV_ZERO;
                                    else if (b == '1) a = '0 - a;
                                    else a = $signed(a) / $signed(b);
                                end
                                default:  a = (a == b) ? 64'd1 : 64'd0;
                            endcase
                            if (e == sme_pkg::ERR_OK) begin
                                stk[n - 2] = a;
                                scnt_m = n - 1;
                                ptr_m = ip + 1;
                            end
                        end
                    end
                    sme_pkg::OP_JMP: ptr_m = iarg;
                    sme_pkg::OP_JMP_NZ: begin
                        if (n < 1) e = sme_pkg::ERR_UNDERFLOW;
                        else if (stk[n - 1] != '0) begin
                            scnt_m = n - 1;
                            ptr_m = iarg;
                        end else begin
                            ptr_m = ip + 1;
                        end
                    end
                    sme_pkg::OP_HALT: halt_m = 1'b1;
                    sme_pkg::OP_PRINT: begin
                        if (n < 1) e = sme_pkg::ERR_UNDERFLOW;
                        else begin
                            r.pv = 1'b1;
                            r.pval = stk[n - 1];
                            scnt_m = n - 1;
                            ptr_m = ip + 1;
                        end
                    end
                    default: e = sme_pkg::ERR_ILLEGAL_INST;
                endcase
            end
        end
        r.err = e;
        r.ptr = ptr_m;
        r.scnt = 11'(scnt_m);
        r.top = (scnt_m > 0) ? stk[scnt_m - 1] : '0;
        r.halt = halt_m;
        r.pcnt = 11'(plen_m);
        return r;
    endfunction

    task automatic send(bit m, logic [3:0] op, logic [63:0] arg, bit typed,
                        t_result tres, output t_result r);
        int gap;
        r = exec_model(m, op, arg);
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            burst_left = $urandom_range(1, 12);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_valid <= 1'b1;
        i_mode <= m;
        i_opcode <= op;
        i_operand <= arg;
        do @(posedge i_clk); while (!o_ready);
        expect_q.push_back(typed ? tres : r);
        beats_in++;
        burst_left--;
    endtask

    task automatic load(logic [3:0] op, logic [63:0] arg, output t_result r);
        send(1'b0, op, arg, 1'b0, r, r);
    endtask

    task automatic step(output t_result r);
        send(1'b1, 4'($urandom), {$urandom, $urandom}, 1'b0, r, r);
    endtask

    task automatic chk_field(string name, logic [63:0] e, logic [63:0] a);
        if (e !== a) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, e, a);
            fail_count++;
        end
    endtask

    // result checker
    initial begin
        t_result e;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                beats_out++;
                if (expect_q.size() == 0) begin
                    $display("%0t: unexpected result beat, got err %0d", $time,
                             o_error_code);
                    fail_count++;
                end else begin
                    e = expect_q.pop_front();
                    err_seen[o_error_code]++;
                    chk_field("error_code", 64'(e.err), 64'(o_error_code));
                    chk_field("next_pointer", e.ptr, o_next_pointer);
                    chk_field("stack_count", 64'(e.scnt), 64'(o_stack_count));
                    chk_field("top_value", e.top, o_top_value);
                    chk_field("halted", 64'(e.halt), 64'(o_halted));
                    chk_field("print_valid", 64'(e.pv), 64'(o_print_valid));
                    chk_field("print_value", e.pval, o_print_value);
                    chk_field("program_count", 64'(e.pcnt), 64'(o_program_count));
                end
            end
        end
    end

    // output back-pressure
    initial begin
        forever begin
            @(posedge i_clk);
            cyc++;
            if (hold_req && !hold_done) begin
                i_ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_done = 1;
            end else begin
                case ((cyc >> 7) % 4)
                    0: i_ready <= 1'b1;
                    1: i_ready <= 1'($urandom_range(0, 1));
                    2: i_ready <= ($urandom_range(0, 3) == 0);
                    default: i_ready <= ((cyc % 7) != 0);
                endcase
            end
        end
    end

    // watchdog
    initial begin
        forever begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
                $display("stack_machine_executor test failed");
                $finish;
            end
        end
    end

    task automatic add_row(bit m, logic [3:0] op, logic [63:0] arg);
        t_dir_row d;
        d.m = m;
        d.op = op;
        d.arg = arg;
        d.typed = 0;
        dir_q.push_back(d);
    endtask

    task automatic add_row_exp(bit m, logic [3:0] op, logic [63:0] arg, t_result x);
        t_dir_row d;
        d.m = m;
        d.op = op;
        d.arg = arg;
        d.typed = 1;
        d.res = x;
        dir_q.push_back(d);
    endtask

    task automatic gen_instr(output logic [3:0] op, output logic [63:0] arg);
        int n;
        n = scnt_m;
        arg = rand_word();
        case ($urandom_range(0, 11))
            0, 1, 2: op = sme_pkg::OP_PUSH;
            3:  op = sme_pkg::OP_DUP_REL;
            4:  op = sme_pkg::OP_PLUS;
            5:  op = sme_pkg::OP_MINUS;
            6:  op = sme_pkg::OP_MULT;
            7:  op = sme_pkg::OP_DIV;
            8:  op = sme_pkg::OP_EQ;
            9:  op = sme_pkg::OP_PRINT;
            10: op = sme_pkg::OP_JMP_NZ;
            default: op = sme_pkg::OP_NOP;
        endcase
        if (n < 2 && op inside {sme_pkg::OP_PLUS, sme_pkg::OP_MINUS, sme_pkg::OP_MULT,
                                sme_pkg::OP_DIV, sme_pkg::OP_EQ})
            op = sme_pkg::OP_PUSH;
        if (n < 1 && op inside {sme_pkg::OP_DUP_REL, sme_pkg::OP_PRINT, sme_pkg::OP_JMP_NZ})
            op = sme_pkg::OP_PUSH;
        if (n >= 900 && op inside {sme_pkg::OP_PUSH, sme_pkg::OP_DUP_REL})
            op = sme_pkg::OP_PRINT;
        if (op == sme_pkg::OP_DIV && stk[n - 1] == '0) op = sme_pkg::OP_MINUS;
        if (op == sme_pkg::OP_DUP_REL) arg = 64'($urandom_range(0, n - 1));
        if (op == sme_pkg::OP_JMP_NZ) arg = 64'(plen_m + 1);
    endtask

    initial begin
        t_result     r;
        t_dir_row    d;
        logic [3:0]  op;
        logic [63:0] arg;
        int ending;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_row_exp(1, 4'hf, WMAX,
                    '{sme_pkg::ERR_BAD_FETCH, '0, '0, '0, 0, 0, '0, '0});
        add_row(0, sme_pkg::OP_PUSH, WMAX);
        add_row(1, 4'h0, '0);
        add_row(0, sme_pkg::OP_PUSH, 64'd1);
        add_row(1, 4'h0, '0);
        add_row(0, sme_pkg::OP_PLUS, '0);
        add_row_exp(1, 4'h0, '0,
                    '{sme_pkg::ERR_OK, 64'd3, 11'd1, WMIN, 0, 0, '0, 11'd3});
        add_row(0, sme_pkg::OP_PUSH, '1);
        add_row(1, 4'h0, '0);
        add_row(0, sme_pkg::OP_DIV, '0);
        add_row_exp(1, 4'h0, '0,
                    '{sme_pkg::ERR_OK, 64'd5, 11'd1, WMIN, 0, 0, '0, 11'd5});
        add_row(0, sme_pkg::OP_DUP_REL, '0);
        add_row(1, 4'h0, '0);
        add_row(0, sme_pkg::OP_MULT, '0);
        add_row_exp(1, 4'h0, '0,
                    '{sme_pkg::ERR_OK, 64'd7, 11'd1, '0, 0, 0, '0, 11'd7});
        add_row(0, sme_pkg::OP_JMP_NZ, 64'd99);
        add_row(1, 4'h0, '0);
        add_row(0, sme_pkg::OP_PUSH, WMIN);
        add_row(1, 4'h0, '0);
        add_row(0, sme_pkg::OP_EQ, '0);
        add_row(1, 4'h0, '0);
        add_row(0, sme_pkg::OP_PRINT, '0);
        add_row_exp(1, 4'h0, '0,
                    '{sme_pkg::ERR_OK, 64'd11, 11'd0, '0, 0, 1, '0, 11'd11});
        add_row(0, sme_pkg::OP_JMP, 64'd12);
        add_row(1, 4'h0, '0);
        foreach (dir_q[k]) begin
            d = dir_q[k];
            send(d.m, d.op, d.arg, d.typed, d.res, r);
        end

        // random programs: pointer tracks the end of the program store
        while (plen_m < 270) begin
            if (plen_m >= 150) hold_req = 1;
            if ($urandom_range(0, 11) == 0) begin
                load(sme_pkg::OP_JMP, 64'(plen_m + 2), r);
                load(4'($urandom), {$urandom, $urandom}, r);
            end else begin
                gen_instr(op, arg);
                load(op, arg, r);
            end
            step(r);
            if ($urandom_range(0, 19) == 0) step(r);
        end

        // one terminal case per run, chosen by the seed
        ending = $urandom_range(0, 5);
        case (ending)
            0: begin
                while (scnt_m >= 2) begin
                    load(sme_pkg::OP_PRINT, '0, r);
                    step(r);
                end
                if ($urandom_range(0, 1) == 0) load(sme_pkg::OP_PLUS, '0, r);
                else load(sme_pkg::OP_DUP_REL, 64'(scnt_m + $urandom_range(0, 3)), r);
                step(r);
                step(r);
            end
            1: begin
                load(4'($urandom_range(12, 15)), rand_word(), r);
                step(r);
                step(r);
            end
            2: begin
                load(sme_pkg::OP_DUP_REL, {1'b1, 31'($urandom), $urandom}, r);
                step(r);
                step(r);
            end
            3: begin
                if (scnt_m == 0) begin
                    load(sme_pkg::OP_PUSH, 64'd7, r);
                    step(r);
                end
                load(sme_pkg::OP_PUSH, '0, r);
                step(r);
                load(sme_pkg::OP_DIV, '0, r);
                step(r);
                step(r);
            end
            4: begin
                load(sme_pkg::OP_HALT, rand_word(), r);
                repeat (3) step(r);
            end
            default: begin
                load(sme_pkg::OP_JMP, ($urandom_range(0, 1) ? WMIN : 64'd5000), r);
                step(r);
                step(r);
            end
        endcase
        i_valid <= 1'b0;

        while (expect_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        $display("Sent %0d beats, checked %0d results, terminal case %0d.",
                 beats_in, beats_out, ending);
        $display("Error codes seen 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
                 err_seen[0], err_seen[1], err_seen[2], err_seen[3],
                 err_seen[4], err_seen[5], err_seen[6], err_seen[7]);
        if (fail_count == 0 && expect_q.size() == 0) begin
            $display("stack_machine_executor test passed");
        end else begin
            $display("stack_machine_executor test failed");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/sme_pkg.sv
rtl/core/sme_alu.sv
rtl/core/sme_controller.sv
rtl/core/sme_datapath.sv
rtl/core/stack_machine_executor.sv
verif/tb.sv
